### hw/rtl/rtaf_pkg.sv
// Shared types, constants and the digit-to-ASCII mapping for the radix formatter.
`default_nettype none

package rtaf_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_SEVEN = 7'd55;  // '7', so 10 maps to 'A'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;  // '9'
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_Z     = 7'd90;  // 'Z'

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture input beat
        logic mul;    // multiply by radix reciprocal
        logic step;   // store remainder, keep quotient
        logic emit;   // load output register with next character
    } rtaf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic q_zero;     // current quotient is zero
        logic last_idx;   // emit index at least significant character
        logic out_free;   // output register can take a character
    } rtaf_sts_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE)
            c = CHAR_ZERO + CHAR_W'(d);
        else
            c = CHAR_SEVEN + CHAR_W'(d);
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rtaf_in_if.sv
// Input channel: number, radix and pad flag with valid/ready.
`default_nettype none

interface rtaf_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            radix;
    logic                  pad_four;

    modport source (output valid, output value, output radix, output pad_four, input ready);
    modport sink   (input valid, input value, input radix, input pad_four, output ready);
endinterface

`default_nettype wire

### hw/rtl/rtaf_out_if.sv
// Output channel: one ASCII character per beat with a last marker.
`default_nettype none

interface rtaf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rtaf_ctrl.sv
// Sequencing state machine for the radix formatter.
`default_nettype none

module rtaf_ctrl
    import rtaf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output rtaf_cmd_t      cmd,
    input  wire rtaf_sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.step   = 1'b1;
                state_next = sts.q_zero ? ST_EMIT : ST_MUL;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_idx)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### hw/rtl/rtaf_dp.sv
// Datapath: reciprocal divide, digit buffer and output register.
`default_nettype none

module rtaf_dp
    import rtaf_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int PAD_DIGITS = 4
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rtaf_in_if.sink         in_ch,
    rtaf_out_if.source      out_ch,
    input  wire rtaf_cmd_t  cmd,
    output rtaf_sts_t       sts
);

    localparam int MAX_DIGITS   = (VALUE_BITS > PAD_DIGITS) ? VALUE_BITS : PAD_DIGITS;
    localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W        = $clog2(MAX_DIGITS);
    // Shift of VALUE_BITS + 6 keeps the ceiling reciprocal exact for radix <= 36.
    localparam int RECIP_SHIFT  = VALUE_BITS + RADIX_W;
    localparam int RECIP_W      = RECIP_SHIFT;
    localparam int PROD_W       = VALUE_BITS + RECIP_W;
    localparam int RADIX_CODES  = 1 << RADIX_W;

    logic [RECIP_W-1:0] recip_tab [RADIX_CODES];

    // Reciprocal table; out-of-range codes hold the clamped radix's entry.
    for (genvar g = 0; g < RADIX_CODES; g++)
    begin : g_recip
        localparam longint unsigned DEN = (g < RADIX_MIN) ? RADIX_MIN :
                                          ((g > RADIX_MAX) ? RADIX_MAX : g);
        localparam longint unsigned RC  = ((64'd1 << RECIP_SHIFT) + DEN - 1) / DEN;
        assign recip_tab[g] = RECIP_W'(RC);
    end

    logic [VALUE_BITS-1:0]         n_reg;
    logic [RADIX_W-1:0]            radix_reg;
    logic                          pad_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              idx_reg;
    logic [RADIX_W-1:0]            digit_reg [MAX_DIGITS];
    logic [CHAR_W-1:0]             char_reg;
    logic                          last_reg;
    logic                          valid_reg;

    logic [RADIX_W-1:0]            radix_clamped;
    logic [VALUE_BITS-1:0]         quot;
    logic [VALUE_BITS+RADIX_W-1:0] qd;
    logic [RADIX_W-1:0]            rem;
    logic [CNT_W-1:0]              cnt_inc;
    logic [CNT_W-1:0]              total;
    logic [CHAR_W-1:0]             emit_char;

    always_comb
    begin
        if (in_ch.radix < RADIX_MIN)
            radix_clamped = RADIX_MIN;
        else if (in_ch.radix > RADIX_MAX)
            radix_clamped = RADIX_MAX;
        else
            radix_clamped = in_ch.radix;
    end

    assign quot    = VALUE_BITS'(prod_reg >> RECIP_SHIFT);
    assign qd      = (VALUE_BITS+RADIX_W)'(quot) * (VALUE_BITS+RADIX_W)'(radix_reg);
    // remainder is below 36, low bits of the difference are exact
    assign rem     = n_reg[RADIX_W-1:0] - qd[RADIX_W-1:0];
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign total   = (pad_reg && (cnt_inc < CNT_W'(PAD_DIGITS))) ? CNT_W'(PAD_DIGITS) : cnt_inc;

    // positions above the digit count are leading pad zeros
    assign emit_char = (idx_reg < cnt_reg) ? digit_to_char(digit_reg[idx_reg[IDX_W-1:0]])
                                           : CHAR_ZERO;

    assign sts.q_zero   = (quot == '0);
    assign sts.last_idx = (idx_reg == '0);
    assign sts.out_free = !valid_reg || out_ch.ready;

    assign out_ch.valid      = valid_reg;
    assign out_ch.digit_char = char_reg;
    assign out_ch.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (out_ch.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg     <= in_ch.value;
            radix_reg <= radix_clamped;
            pad_reg   <= in_ch.pad_four;
            cnt_reg   <= '0;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(n_reg) * PROD_W'(recip_tab[radix_reg]);
        if (cmd.step)
        begin
            digit_reg[cnt_reg[IDX_W-1:0]] <= rem;
            cnt_reg <= cnt_inc;
            n_reg   <= quot;
            idx_reg <= total - CNT_W'(1);
        end
        if (cmd.emit)
        begin
            char_reg <= emit_char;
            last_reg <= sts.last_idx;
            idx_reg  <= idx_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/radix_to_ascii_formatter_core.sv
// Top level of the radix-to-ASCII formatter: controller, datapath and checks.
//
// Usage:
//   in_ch carries one number per beat: value, radix (2..36; 0..1 act as 2,
//   37..63 act as 36) and pad_four. out_ch returns the number's ASCII digits,
//   most significant first, one character per beat; last marks the final one.
//   With pad_four set, leading '0' beats bring the count to PAD_DIGITS.
// Timing:
//   After a beat is accepted, each digit takes a multiply by the radix
//   reciprocal (ST_MUL), then the quotient/remainder fix-up (ST_REM). The
//   shared reciprocal multiplier sets the digit rate. Then one character per
//   cycle moves into the output register while the sink keeps ready high.
//   One number is in work at a time; in_ch.ready rises again as soon as the
//   last character sits in the output register, so the next number's digits
//   are computed while that character waits for the sink.
// Reset and stalls:
//   rst_n clears the controller and the output valid; no clearing pass.
//   A stalled sink holds the output register and pauses character emission.
`default_nettype none

module radix_to_ascii_formatter_core
    import rtaf_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int PAD_DIGITS = 4
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rtaf_in_if.sink    in_ch,
    rtaf_out_if.source out_ch
);

    rtaf_cmd_t cmd;
    rtaf_sts_t sts;
    logic      in_ready;

    assign in_ch.ready = in_ready;

    rtaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rtaf_dp #(
        .VALUE_BITS (VALUE_BITS),
        .PAD_DIGITS (PAD_DIGITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .sts    (sts)
    );

    // Only one command per cycle from the sequencer
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.step, cmd.emit}))
        else $error("rtaf: overlapping commands");

    // Once a number is taken, no new one until its characters are produced
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("rtaf: input accepted while busy");

    // Characters stay within '0'..'9' and 'A'..'Z'
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |->
            (out_ch.digit_char >= CHAR_ZERO && out_ch.digit_char <= CHAR_NINE) ||
            (out_ch.digit_char >= CHAR_A && out_ch.digit_char <= CHAR_Z))
        else $error("rtaf: character out of range");

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the radix-to-ASCII formatter core.
`default_nettype none

module testbench
    import rtaf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS   = 16;
    localparam int PAD_DIGITS   = 4;
    localparam int RANDOM_ITEMS = 360;
    // The tail wait covers the worst item's digit work.
    localparam int TAIL_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 400000;
    // Long receiver hold-off: starts once this many characters have arrived.
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;

    // One number offered on the input channel. wait_idle makes the sender
    // sit idle until every predicted character has come back first.
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
        logic                  pad_four;
        bit                    wait_idle;
    } number_t;

    // One predicted output beat.
    typedef struct {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } char_t;

    // Receiver behavior outside the long hold-off.
    typedef enum logic [1:0] {
        RX_STEADY,   // ready every cycle
        RX_RANDOM,   // ready with a chance of about two in three
        RX_SPARSE    // ready with a chance of one in four
    } rx_mode_t;

    logic clk;
    logic rst_n;

    rtaf_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch();
    rtaf_out_if                           out_ch();

    radix_to_ascii_formatter_core #(
        .VALUE_BITS(VALUE_BITS),
        .PAD_DIGITS(PAD_DIGITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    number_t number_q[$];   // numbers still to be offered
    char_t   char_q[$];     // characters predicted but not yet seen

    int numbers_total;
    int numbers_accepted;
    int err_count;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Block inputs get their reset values from the driver and receiver
    // processes as soon as rst_n falls.
    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor: digits of value in the clamped radix, most significant
    // first, padded with '0' to PAD_DIGITS when pad_four is set.
    // ------------------------------------------------------------------
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                           input logic [RADIX_W-1:0]    radix_raw,
                                           input logic                  pad_four);
        logic [RADIX_W-1:0] base;
        logic [CHAR_W-1:0]  lsd_first[$];
        int unsigned        n;
        int unsigned        d;
        char_t              c;
        // Radix 0 and 1 act as binary; anything past 36 acts as 36.
        if (radix_raw < RADIX_MIN)
            base = RADIX_MIN;
        else if (radix_raw > RADIX_MAX)
            base = RADIX_MAX;
        else
            base = radix_raw;
        n = 32'(value);
        // At least one digit, so zero still yields '0'.
        do
        begin
            d = n % base;
            if (d < DEC_BASE)
                lsd_first.push_back(CHAR_ZERO + CHAR_W'(d));
            else
                lsd_first.push_back(CHAR_SEVEN + CHAR_W'(d));
            n = n / base;
        end
        while (n != 0);
        // Long numbers already at PAD_DIGITS get no padding.
        if (pad_four)
            while (lsd_first.size() < PAD_DIGITS)
                lsd_first.push_back(CHAR_ZERO);
        for (int k = lsd_first.size() - 1; k >= 0; k--)
        begin
            c.digit_char = lsd_first[k];
            c.last       = (k == 0);
            char_q.push_back(c);
        end
    endfunction

    task automatic add_number(input logic [VALUE_BITS-1:0] value,
                              input logic [RADIX_W-1:0]    radix,
                              input logic                  pad_four,
                              input bit                    wait_idle);
        number_t item;
        item.value     = value;
        item.radix     = radix;
        item.pad_four  = pad_four;
        item.wait_idle = wait_idle;
        number_q.push_back(item);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of back-to-back beats separated by random gaps.
    // A beat held on the bus is never dropped until it is taken.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        number_t item;
        bit      fire;
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.value    <= '0;
            in_ch.radix    <= '0;
            in_ch.pad_four <= 1'b0;
            burst_left     = 1;
            gap_left       = 0;
        end
        else
        begin
            fire = in_ch.valid && in_ch.ready;
            if (fire)
            begin
                predict_digits(in_ch.value, in_ch.radix, in_ch.pad_four);
                numbers_accepted++;
            end
            // A beat still waiting for ready stays as it is.
            if (!in_ch.valid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (number_q.size() == 0)
                    in_ch.valid <= 1'b0;
                else if (number_q[0].wait_idle && char_q.size() != 0)
                    in_ch.valid <= 1'b0;   // drain the block before this one
                else
                begin
                    item = number_q.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.value    <= item.value;
                    in_ch.radix    <= item.radix;
                    in_ch.pad_four <= item.pad_four;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // Half the bursts run straight into the next one.
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard on the output channel, plus the receiver's
    // stall pattern and the single long hold-off.
    // ------------------------------------------------------------------
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    bit       hold_done;
    int       chars_seen;

    always @(posedge clk or negedge rst_n)
    begin
        char_t exp_c;
        logic  ready_next;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_mode      = RX_STEADY;
            mode_left    = 0;
            hold_left    = 0;
            hold_done    = 0;
            chars_seen   = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                chars_seen++;
                if (char_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual char 0x%02h last %0b",
                             $realtime, out_ch.digit_char, out_ch.last);
                    err_count++;
                end
                else
                begin
                    exp_c = char_q.pop_front();
                    if (out_ch.digit_char !== exp_c.digit_char)
                    begin
                        $display("%0t: digit_char mismatch, expected 0x%02h actual 0x%02h",
                                 $realtime, exp_c.digit_char, out_ch.digit_char);
                        err_count++;
                    end
                    if (out_ch.last !== exp_c.last)
                    begin
                        $display("%0t: last mismatch, expected %0b actual %0b",
                                 $realtime, exp_c.last, out_ch.last);
                        err_count++;
                    end
                end
            end

            // Long hold-off: the block fills up and must stall its input.
            if (!hold_done && chars_seen >= HOLD_AFTER)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 200);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_STEADY: ready_next = 1'b1;
                    RX_RANDOM: ready_next = ($urandom_range(0, 2) != 0);
                    default:   ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ch.ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int cycle_count;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [VALUE_BITS-1:0] v;
        logic [RADIX_W-1:0]    r;
        numbers_accepted = 0;
        err_count        = 0;
        cycle_count      = 0;

        // Directed: zero, full scale, every radix clamp and the padding rules.
        add_number(16'd0,     6'd10, 1'b0, 0);   // zero gives a single '0'
        add_number(16'd0,     6'd10, 1'b1, 0);   // zero padded to "0000"
        add_number(16'hFFFF,  6'd2,  1'b0, 0);   // sixteen binary digits
        add_number(16'hFFFF,  6'd2,  1'b1, 0);   // long result, no padding
        add_number(16'hFFFF,  6'd36, 1'b0, 0);   // "1EKF"
        add_number(16'hFFFF,  6'd16, 1'b1, 0);   // exactly four digits
        add_number(16'd5,     6'd0,  1'b0, 0);   // radix zero acts as binary
        add_number(16'hFFFF,  6'd1,  1'b1, 0);   // radix one acts as binary
        add_number(16'd35,    6'd63, 1'b0, 0);   // radix past 36 clamps, 'Z'
        add_number(16'd1295,  6'd37, 1'b0, 0);   // "ZZ"
        add_number(16'd35,    6'd36, 1'b1, 0);   // "000Z"
        add_number(16'd12345, 6'd10, 1'b0, 0);
        add_number(16'd7,     6'd10, 1'b1, 0);   // "0007"
        add_number(16'd255,   6'd16, 1'b1, 0);   // "00FF"
        add_number(16'd1000,  6'd10, 1'b1, 0);   // four digits, no padding
        add_number(16'd255,   6'd8,  1'b0, 0);   // byte-wide use
        add_number(16'd0,     6'd0,  1'b1, 0);
        add_number(16'h8000,  6'd2,  1'b0, 0);
        add_number(16'd9,     6'd10, 1'b0, 0);   // '9' boundary
        add_number(16'd10,    6'd11, 1'b0, 0);   // 'A' boundary
        add_number(16'hAAAA,  6'd3,  1'b1, 1);   // sender waits for a drained block
        add_number(16'h5555,  6'd7,  1'b0, 0);

        // Random part.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    v = VALUE_BITS'($urandom_range(0, 255));   // byte-wide values
                2:       v = VALUE_BITS'($urandom_range(0, 15));
                3:       v = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                default: v = VALUE_BITS'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:       r = RADIX_W'($urandom_range(0, 63));       // clamps included
                1:       r = $urandom_range(0, 1) ? RADIX_MIN : RADIX_MAX;
                2:       r = DEC_BASE;
                3:       r = 6'd16;
                default: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            endcase
            add_number(v, r, 1'($urandom_range(0, 1)), (i == 120) || (i == 250));
        end
        numbers_total = number_q.size();

        @(posedge rst_n);
        while (numbers_accepted < numbers_total)
            @(posedge clk);
        while (char_q.size() != 0)
            @(posedge clk);
        // Any stray beat after the last expected one is caught meanwhile.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
